FILE: sv/assert_macros.svh
// assertion macros used by the rtl file gf256_arith_unit.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: label");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

FILE: sv/gfau_pkg.sv
// types, constants and helper functions of the gf(2^8) arithmetic unit
package gfau_pkg;

    localparam int BYTE_W    = 8;
    localparam int NUM_CELLS = BYTE_W;
    localparam int IDX_W     = $clog2(BYTE_W);

    localparam logic [BYTE_W-1:0] GF_TOP_BIT    = 8'h80;
    localparam logic [BYTE_W-1:0] GF_ONE        = 8'h01;
    localparam logic [BYTE_W-1:0] GF_POLY_RESET = 8'h1b;

    typedef enum logic [1:0] {
        GFAU_ADD = 2'd0,
        GFAU_MUL = 2'd1,
        GFAU_INV = 2'd2
    } gfau_mode_t;

    // one item as it travels down the chain of cells
    typedef struct packed {
        gfau_mode_t                        mode;
        logic [BYTE_W-1:0]                 add_res;
        logic                              a_nz;
        logic [BYTE_W-1:0]                 term;
        logic [BYTE_W-1:0]                 acc;
        logic [BYTE_W-1:0]                 b_rem;
        logic [BYTE_W-1:0][BYTE_W-1:0]     cols;
        logic [BYTE_W-1:0]                 rhs;
        logic [BYTE_W-1:0]                 used;
        logic [BYTE_W-1:0][IDX_W-1:0]      piv;
        logic                              singular;
    } gfau_item_t;

    function automatic logic [BYTE_W-1:0] gfau_xtime(
        input logic [BYTE_W-1:0] v,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] shifted;
        shifted = {v[BYTE_W-2:0], 1'b0};
        if ((v & GF_TOP_BIT) != '0) begin
            shifted = shifted ^ poly;
        end
        return shifted;
    endfunction

    // index of the lowest set bit, zero when none is set
    function automatic logic [IDX_W-1:0] gfau_lowest(input logic [BYTE_W-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/gfau_mul_cell.sv
// shift-and-add cell: one bit of operand_b per cell, also collects a*x^k columns
module gfau_mul_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [gfau_pkg::BYTE_W-1:0] poly,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  gfau_pkg::gfau_item_t      in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output gfau_pkg::gfau_item_t      out_item
);

    logic                 valid_reg;
    logic                 valid_next;
    gfau_pkg::gfau_item_t item_reg;
    gfau_pkg::gfau_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_comb begin
        item_next = in_item;
        if (in_item.b_rem[0]) begin
            item_next.acc = in_item.acc ^ in_item.term;
        end
        item_next.term  = gfau_pkg::gfau_xtime(in_item.term, poly);
        item_next.b_rem = in_item.b_rem >> 1;
        // newest column enters at the top, first column ends at index zero
        item_next.cols  = {in_item.term, in_item.cols[gfau_pkg::BYTE_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: sv/gfau_piv_cell.sv
// gauss-jordan cell: pivots on column zero, then rotates the columns by one
module gfau_piv_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gfau_pkg::gfau_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gfau_pkg::gfau_item_t out_item
);

    logic                                          valid_reg;
    logic                                          valid_next;
    gfau_pkg::gfau_item_t                          item_reg;
    gfau_pkg::gfau_item_t                          item_next;
    logic [gfau_pkg::BYTE_W-1:0]                   avail;
    logic                                          found;
    logic [gfau_pkg::IDX_W-1:0]                    p;
    logic [gfau_pkg::BYTE_W-1:0]                   p_bit;
    logic [gfau_pkg::BYTE_W-1:0]                   mask;
    logic [gfau_pkg::BYTE_W-1:0][gfau_pkg::BYTE_W-1:0] cols_red;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_comb begin
        avail = in_item.cols[0] & ~in_item.used;
        found = |avail;
        p     = gfau_pkg::gfau_lowest(avail);
        p_bit = gfau_pkg::BYTE_W'(1) << p;
        // rows other than the pivot row that carry this variable
        mask  = found ? (in_item.cols[0] & ~p_bit) : '0;

        item_next = in_item;
        for (int j = 0; j < gfau_pkg::BYTE_W; j++) begin
            cols_red[j] = in_item.cols[j] ^ (in_item.cols[j][p] ? mask : '0);
        end
        item_next.rhs      = in_item.rhs ^ (in_item.rhs[p] ? mask : '0);
        item_next.cols     = {cols_red[0], cols_red[gfau_pkg::BYTE_W-1:1]};
        item_next.used     = in_item.used | (found ? p_bit : '0);
        item_next.piv      = {p, in_item.piv[gfau_pkg::BYTE_W-1:1]};
        item_next.singular = in_item.singular | !found;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: sv/gf256_arith_unit.sv
// gf(2^8) arithmetic unit: add, multiply and inverse under a configurable polynomial
// items pass through 8 multiply cells, then 8 pivot cells and one output register
// throughput: one item per cycle while m_tready does not stall the output; each cell is a stage with its own handshake
// inverse solves a*b = 1 by gauss-jordan elimination, one column per pivot cell
// reset clears all valid flags and loads poly_reg with 0x1b
`include "assert_macros.svh"

module gf256_arith_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operand_a [7:0], operand_b [15:8]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // result [7:0]
    output logic        m_tuser    // no_inverse [0]
);

    localparam int NC = gfau_pkg::NUM_CELLS;

    logic [gfau_pkg::BYTE_W-1:0] poly_reg;
    logic [gfau_pkg::BYTE_W-1:0] poly_next;

    logic [2*NC:0]        st_valid;
    logic [2*NC:0]        st_ready;
    gfau_pkg::gfau_item_t st_item [2*NC+1];
    gfau_pkg::gfau_item_t head_item;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [gfau_pkg::BYTE_W-1:0] m_data_reg;
    logic [gfau_pkg::BYTE_W-1:0] m_data_next;
    logic                        m_user_reg;
    logic                        m_user_next;
    logic [gfau_pkg::BYTE_W-1:0] inv_byte;
    gfau_pkg::gfau_item_t        last_item;

    // configuration register
    always_comb begin
        poly_next = cfg_wr_en ? cfg_wr_data : poly_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= gfau_pkg::GF_POLY_RESET;
        end else begin
            poly_reg <= poly_next;
        end
    end

    // item entering the chain
    assign st_valid[0] = s_tvalid;
    assign s_tready    = st_ready[0];

    always_comb begin
        head_item          = '0;
        head_item.mode     = gfau_pkg::gfau_mode_t'(s_tuser);
        head_item.add_res  = s_tdata[7:0] ^ s_tdata[15:8];
        head_item.a_nz     = |s_tdata[7:0];
        head_item.term     = s_tdata[7:0];
        head_item.b_rem    = s_tdata[15:8];
        head_item.rhs      = gfau_pkg::GF_ONE;
    end

    assign st_item[0] = head_item;

    for (genvar i = 0; i < NC; i++) begin : g_mul
        gfau_mul_cell u_mul (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .poly      (poly_reg),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_item   (st_item[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_item  (st_item[i+1])
        );
    end

    for (genvar i = NC; i < 2*NC; i++) begin : g_piv
        gfau_piv_cell u_piv (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_item   (st_item[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_item  (st_item[i+1])
        );
    end

    // output register
    assign last_item    = st_item[2*NC];
    assign st_ready[2*NC] = !m_valid_reg || m_tready;

    always_comb begin
        // each pivot row ends up holding its variable's value in the right-hand side
        for (int k = 0; k < gfau_pkg::BYTE_W; k++) begin
            inv_byte[k] = last_item.rhs[last_item.piv[k]];
        end
        unique case (last_item.mode)
            gfau_pkg::GFAU_ADD: begin
                m_data_next = last_item.add_res;
                m_user_next = 1'b0;
            end
            gfau_pkg::GFAU_MUL: begin
                m_data_next = last_item.acc;
                m_user_next = 1'b0;
            end
            gfau_pkg::GFAU_INV: begin
                m_data_next = last_item.singular ? '0 : inv_byte;
                m_user_next = last_item.singular && last_item.a_nz;
            end
            default: begin
                m_data_next = '0;
                m_user_next = 1'b0;
            end
        endcase
        m_valid_next = st_ready[2*NC] ? st_valid[2*NC] : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_ready[2*NC] && st_valid[2*NC]) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a flagged result always carries a zero byte
    `ASSERT_NEVER(a_flag_zero, aclk, aresetn, m_valid_reg && m_user_reg && (m_data_reg != '0))
    // an empty output register lets the whole chain take a transfer
    `ASSERT_ALWAYS(a_ready_empty, aclk, aresetn, !m_valid_reg |-> s_tready)
    // polynomial holds the aes default right after reset
    `ASSERT_ALWAYS(a_poly_reset, aclk, aresetn, $rose(aresetn) |-> (poly_reg == gfau_pkg::GF_POLY_RESET))

endmodule

FILE: tb/tb_gf256_arith_unit.sv
// self-checking testbench for the gf(2^8) add / multiply / inverse unit
`timescale 1ns / 100ps

module tb_gf256_arith_unit;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_GAP = 17;
    localparam int DRAIN_PAUSE = 20;      // pipeline latency plus margin
    localparam int CHOKE_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES = 9;
    localparam int OPS_PER_PHASE = 117;
    localparam int NUM_ROWS = 25;

    typedef struct packed {
        logic [7:0] value;
        logic       no_inverse;
    } gf_outcome_t;

    typedef struct packed {
        logic [7:0] poly;
        logic [1:0] mode;
        logic [7:0] a;
        logic [7:0] b;
        logic       typed;
        logic [7:0] value;
        logic       no_inverse;
    } gf_row_t;

    // value and flag are typed in only where obvious, otherwise taken from the predictor
    localparam gf_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{8'h1b, gfau_pkg::GFAU_ADD, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_ADD, 8'hff, 8'hff, 1'b1, 8'h00, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_ADD, 8'hff, 8'h00, 1'b1, 8'hff, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_ADD, 8'ha5, 8'h5a, 1'b1, 8'hff, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_MUL, 8'h00, 8'hff, 1'b1, 8'h00, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_MUL, 8'hff, 8'h01, 1'b1, 8'hff, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_MUL, 8'h80, 8'h02, 1'b1, 8'h1b, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_MUL, 8'h57, 8'h83, 1'b1, 8'hc1, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_MUL, 8'hff, 8'hff, 1'b0, 8'h00, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_MUL, 8'h80, 8'h80, 1'b0, 8'h00, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_INV, 8'h00, 8'hff, 1'b1, 8'h00, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_INV, 8'h01, 8'h00, 1'b1, 8'h01, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_INV, 8'h53, 8'hff, 1'b1, 8'hca, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_INV, 8'hff, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h1b, gfau_pkg::GFAU_INV, 8'h80, 8'h80, 1'b0, 8'h00, 1'b0},
        '{8'h1b, MODE_UNUSED, 8'hff, 8'hff, 1'b1, 8'h00, 1'b0},
        '{8'h1b, MODE_UNUSED, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        // x^8 alone: only elements with a constant term are invertible
        '{8'h00, gfau_pkg::GFAU_INV, 8'h02, 8'h00, 1'b1, 8'h00, 1'b1},
        '{8'h00, gfau_pkg::GFAU_INV, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{8'h00, gfau_pkg::GFAU_MUL, 8'h80, 8'h02, 1'b1, 8'h00, 1'b0},
        '{8'h00, gfau_pkg::GFAU_INV, 8'hff, 8'h00, 1'b0, 8'h00, 1'b0},
        '{8'hff, gfau_pkg::GFAU_MUL, 8'h80, 8'h02, 1'b1, 8'hff, 1'b0},
        '{8'hff, gfau_pkg::GFAU_INV, 8'h80, 8'h00, 1'b0, 8'h00, 1'b0},
        // x^8 + 1 = (x + 1)^8, so x + 1 has no inverse
        '{8'h01, gfau_pkg::GFAU_INV, 8'h03, 8'h00, 1'b1, 8'h00, 1'b1},
        '{8'h01, gfau_pkg::GFAU_INV, 8'h02, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    logic [7:0]  poly_model = gfau_pkg::GF_POLY_RESET;
    gf_outcome_t pending_outcomes [$];
    gf_outcome_t rx_want;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          rx_wait = 0;
    int          choke_left = 0;
    bit          choke_req = 1'b0;
    bit          choke_taken = 1'b0;
    bit          tx_fast = 1'b0;
    bit          rx_fast = 1'b0;

    gf256_arith_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] gf_twice(input logic [7:0] v);
        logic [7:0] shifted;
        shifted = {v[6:0], 1'b0};
        if ((v & gfau_pkg::GF_TOP_BIT) != 8'h00) begin
            shifted = shifted ^ poly_model;
        end
        return shifted;
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] term;
        acc = 8'h00;
        term = x;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) begin
                acc = acc ^ term;
            end
            term = gf_twice(term);
        end
        return acc;
    endfunction

    function automatic gf_outcome_t gf_evaluate(input logic [1:0] mode, input logic [7:0] a,
                                                input logic [7:0] b);
        gf_outcome_t o;
        o.value = 8'h00;
        o.no_inverse = 1'b0;
        case (mode)
            gfau_pkg::GFAU_ADD: o.value = a ^ b;
            gfau_pkg::GFAU_MUL: o.value = gf_times(a, b);
            gfau_pkg::GFAU_INV: begin
                if (a != 8'h00) begin
                    // smallest candidate wins; flag stays set if none works
                    o.no_inverse = 1'b1;
                    for (int c = 1; c < 256 && o.no_inverse; c++) begin
                        if (gf_times(a, 8'(c)) == gfau_pkg::GF_ONE) begin
                            o.value = 8'(c);
                            o.no_inverse = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int draw_gap(input bit fast);
        return fast ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // mostly uniform, sometimes one of the corner bytes
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [4];
        corners = '{8'h00, 8'h01, 8'h80, 8'hff};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 3)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_op(input logic [1:0] mode, input logic [7:0] a, input logic [7:0] b,
                           input gf_outcome_t want, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outcomes.push_back(want);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic load_poly(input logic [7:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        poly_model = value;
    endtask

    // result side: check every transfer, stall for a drawn number of cycles, honour the choke request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("unexpected transfer: result %02h no_inverse %0b", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    rx_want = pending_outcomes.pop_front();
                    if (m_tdata !== rx_want.value) begin
                        $error("result: expected %02h, actual %02h", rx_want.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== rx_want.no_inverse) begin
                        $error("no_inverse: expected %0b, actual %0b",
                               rx_want.no_inverse, m_tuser);
                        fail_count++;
                    end
                end
                rx_wait = draw_gap(rx_fast);
            end
            if (choke_req && !choke_taken) begin
                choke_taken = 1'b1;
                choke_left = CHOKE_CYCLES;
            end
            if (choke_left > 0) begin
                choke_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** gf256_arith_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0]  phase_poly [NUM_PHASES];
        logic [1:0]  mode;
        logic [7:0]  a;
        logic [7:0]  b;
        gf_outcome_t want;
        int          pick;

        phase_poly = '{8'h1b, 8'h00, 8'hff, 8'h01, 8'h1d, 8'h80, 8'h00, 8'h00, 8'h00};
        for (int p = 6; p < NUM_PHASES; p++) begin
            phase_poly[p] = 8'($urandom_range(0, 255));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, first ones under the reset polynomial
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIRECTED_ROWS[r].poly != poly_model) begin
                load_poly(DIRECTED_ROWS[r].poly);
            end
            if (DIRECTED_ROWS[r].typed) begin
                want.value = DIRECTED_ROWS[r].value;
                want.no_inverse = DIRECTED_ROWS[r].no_inverse;
            end else begin
                want = gf_evaluate(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].a,
                                   DIRECTED_ROWS[r].b);
            end
            send_op(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].a, DIRECTED_ROWS[r].b, want,
                    draw_gap(1'b0));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            load_poly(phase_poly[p]);
            tx_fast = (p == 1 || p == 4);
            rx_fast <= (p == 4 || p == 6);
            // back-to-back input while the result side holds off: fills the pipeline
            if (p == 1) begin
                choke_req <= 1'b1;
            end
            for (int i = 0; i < OPS_PER_PHASE; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    mode = gfau_pkg::GFAU_ADD;
                end else if (pick < 65) begin
                    mode = gfau_pkg::GFAU_MUL;
                end else if (pick < 96) begin
                    mode = gfau_pkg::GFAU_INV;
                end else begin
                    mode = MODE_UNUSED;
                end
                a = pick_byte();
                b = pick_byte();
                send_op(mode, a, b, gf_evaluate(mode, a, b), draw_gap(tx_fast));
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("** gf256_arith_unit: PASSED **");
        end else begin
            $display("** gf256_arith_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/gfau_pkg.sv
sv/gfau_mul_cell.sv
sv/gfau_piv_cell.sv
sv/gf256_arith_unit.sv
tb/tb_gf256_arith_unit.sv
